@@ design/rdc_pkg.sv @@
// Constants and helpers for the radix digit converter.
// No dependencies; used by radix_digit_converter_top.
package rdc_pkg;

    localparam int unsigned RADIX_W = 6;
    localparam int unsigned CHAR_W  = 7;

    localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
    localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
    localparam logic [RADIX_W-1:0] DEC_DIGITS  = 6'd10;

    localparam logic [CHAR_W-1:0] ASCII_ZERO   = 7'd48;
    localparam logic [CHAR_W-1:0] ASCII_LETTER = 7'd55;

    typedef logic [RADIX_W-1:0] digit_t;
    typedef logic [CHAR_W-1:0]  char_t;

    function automatic char_t digit_to_ascii(input digit_t d);
        if (d < DEC_DIGITS) begin
            return ASCII_ZERO + {1'b0, d};
        end else begin
            return ASCII_LETTER + {1'b0, d};
        end
    endfunction

    function automatic digit_t clamp_radix(input digit_t r);
        if (r < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            return RADIX_MAX;
        end else begin
            return r;
        end
    endfunction

endpackage

@@ design/radix_digit_converter_top.sv @@
// Signed integer to radix 2..36 ASCII digit stream, bit-serial long division.
// Depends on rdc_pkg.
//
//  channel | dir | handshake         | payload
//  --------+-----+-------------------+------------------------------------------
//  s_      | in  | s_tvalid/s_tready | s_tdata[63:0] value
//  m_      | out | m_tvalid/m_tready | m_tdata digit_char, m_tuser negative, m_tlast
//  cfg_    | in  | cfg_wr_en         | cfg_wr_data out_radix
//
// Each digit is found by restoring division, one quotient bit per cycle. Once
// all digits are stored, each is read from the digit store (ST_READ, ST_LOAD)
// and presented (ST_SEND), where it waits for m_tready while the output stalls.
// Reset clears control state and sets the radix to ten; the digit store is
// not cleared. One item is converted at a time; s_tready is high only idle.
module radix_digit_converter_top
    import rdc_pkg::*;
#(
    parameter int unsigned VALUE_BITS = 64,
    parameter int unsigned MAX_DIGITS = 64
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_wr_en,
    input  logic [5:0]   cfg_wr_data,  // [5:0] out_radix
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [63:0]  s_tdata,      // [63:0] value
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [7:0]   m_tdata,      // [6:0] digit_char, [7] zero
    output logic         m_tuser,      // [0] negative
    output logic         m_tlast
);

    localparam int unsigned BW = $clog2(VALUE_BITS);
    localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
    localparam int unsigned AW = $clog2(MAX_DIGITS);
    localparam logic [BW-1:0] BIT_LAST = BW'(VALUE_BITS - 1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_DIGITS);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_READ = 3'd2;
    localparam logic [2:0] ST_LOAD = 3'd3;
    localparam logic [2:0] ST_SEND = 3'd4;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] quot_reg, quot_next;
    digit_t                rem_reg, rem_next;
    logic [BW-1:0]         bit_reg, bit_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic                  neg_reg, neg_next;
    logic                  valid_reg, valid_next;
    logic                  last_reg, last_next;
    char_t                 char_reg, char_next;
    digit_t                radix_reg;
    digit_t                rd_data_reg;
    digit_t                digit_store [MAX_DIGITS];

    digit_t                radix_eff;
    logic [6:0]            trial;
    logic [6:0]            trial_diff;
    logic                  trial_ge;
    digit_t                rem_step;
    logic [VALUE_BITS-1:0] quot_step;
    logic [VALUE_BITS-1:0] v_low;
    logic [VALUE_BITS-1:0] v_mag;
    logic                  wr_en;
    logic [CW-1:0]         cnt_inc;

    assign radix_eff  = clamp_radix(radix_reg);
    assign trial      = {rem_reg, quot_reg[VALUE_BITS-1]};
    assign trial_ge   = trial >= {1'b0, radix_eff};
    assign trial_diff = trial - {1'b0, radix_eff};
    assign rem_step   = trial_ge ? trial_diff[5:0] : trial[5:0];
    assign quot_step  = {quot_reg[VALUE_BITS-2:0], trial_ge};
    assign v_low      = s_tdata[VALUE_BITS-1:0];
    assign v_mag      = v_low[VALUE_BITS-1]
                      ? (~v_low + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : v_low;
    assign wr_en      = (state_reg == ST_DIV) && (bit_reg == BIT_LAST);
    assign cnt_inc    = cnt_reg + {{(CW-1){1'b0}}, 1'b1};

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, char_reg};
    assign m_tuser  = neg_reg;
    assign m_tlast  = last_reg;

    always_comb begin
        state_next = state_reg;
        quot_next  = quot_reg;
        rem_next   = rem_reg;
        bit_next   = bit_reg;
        cnt_next   = cnt_reg;
        addr_next  = addr_reg;
        neg_next   = neg_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        char_next  = char_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    quot_next  = v_mag;
                    rem_next   = '0;
                    bit_next   = '0;
                    cnt_next   = '0;
                    neg_next   = v_low[VALUE_BITS-1];
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                quot_next = quot_step;
                rem_next  = rem_step;
                bit_next  = bit_reg + {{(BW-1){1'b0}}, 1'b1};
                if (bit_reg == BIT_LAST) begin
                    bit_next = '0;
                    rem_next = '0;
                    cnt_next = cnt_inc;
                    if ((quot_step == '0) || (cnt_inc == CNT_MAX)) begin
                        addr_next  = cnt_reg[AW-1:0];
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                char_next  = digit_to_ascii(rd_data_reg);
                last_next  = (addr_reg == '0);
                valid_next = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    if (last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        addr_next  = addr_reg - {{(AW-1){1'b0}}, 1'b1};
                        state_next = ST_READ;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            bit_reg   <= '0;
            cnt_reg   <= '0;
            radix_reg <= RADIX_RESET;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            bit_reg   <= bit_next;
            cnt_reg   <= cnt_next;
            if (cfg_wr_en) begin
                radix_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        addr_reg <= addr_next;
        neg_reg  <= neg_next;
        last_reg <= last_next;
        char_reg <= char_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            digit_store[cnt_reg[AW-1:0]] <= rem_step;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= digit_store[addr_reg];
        end
    end

endmodule
